// ----- rtl/dtq_pkg.sv -----
package dtq_pkg;

  localparam int HANDLE_W      = 4;
  localparam int HANDLE_COUNT  = 16;
  localparam int DELAY_W       = 32;
  localparam int KIND_W        = 2;
  localparam int DEF_SLOTS     = 16;
  localparam int DEF_TIME_BITS = 48;

  typedef enum logic [KIND_W-1:0] {
    KIND_ARM    = 2'd0,
    KIND_CANCEL = 2'd1,
    KIND_TICK   = 2'd2
  } dtq_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REMOVE,
    ST_INSERT,
    ST_FIRE
  } dtq_state_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_REMOVE,
    OP_INSERT
  } dtq_op_t;

  typedef struct packed {
    dtq_op_t             op;
    logic [HANDLE_W-1:0] key;
  } dtq_ctrl_t;

endpackage

// ----- rtl/dtq_cell.sv -----
module dtq_cell #(
  parameter int TIME_BITS = dtq_pkg::DEF_TIME_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  dtq_pkg::dtq_ctrl_t           ctrl,
  input  logic [TIME_BITS-1:0]         new_deadline,
  input  logic                         prev_valid,
  input  logic [dtq_pkg::HANDLE_W-1:0] prev_handle,
  input  logic [TIME_BITS-1:0]         prev_deadline,
  input  logic                         prev_ins,
  input  logic                         next_valid,
  input  logic [dtq_pkg::HANDLE_W-1:0] next_handle,
  input  logic [TIME_BITS-1:0]         next_deadline,
  input  logic                         rm_in,
  output logic                         rm_out,
  output logic                         ins_out,
  output logic                         valid,
  output logic [dtq_pkg::HANDLE_W-1:0] handle,
  output logic [TIME_BITS-1:0]         deadline
);

  logic                         valid_r, valid_nxt;
  logic [dtq_pkg::HANDLE_W-1:0] handle_r, handle_nxt;
  logic [TIME_BITS-1:0]         deadline_r, deadline_nxt;

  // insertion point: first empty cell or first strictly later deadline
  assign ins_out = !valid_r || (deadline_r > new_deadline);
  // everything at or after the matching entry shifts toward the head
  assign rm_out  = rm_in || (valid_r && (handle_r == ctrl.key));

  always_comb begin
    valid_nxt    = valid_r;
    handle_nxt   = handle_r;
    deadline_nxt = deadline_r;
    case (ctrl.op)
      dtq_pkg::OP_REMOVE: begin
        if (rm_out) begin
          valid_nxt    = next_valid;
          handle_nxt   = next_handle;
          deadline_nxt = next_deadline;
        end
      end
      dtq_pkg::OP_INSERT: begin
        if (prev_ins) begin
          valid_nxt    = prev_valid;
          handle_nxt   = prev_handle;
          deadline_nxt = prev_deadline;
        end else if (ins_out) begin
          valid_nxt    = 1'b1;
          handle_nxt   = ctrl.key;
          deadline_nxt = new_deadline;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    handle_r   <= handle_nxt;
    deadline_r <= deadline_nxt;
  end

  assign valid    = valid_r;
  assign handle   = handle_r;
  assign deadline = deadline_r;

endmodule

// ----- rtl/deadline_timer_queue.sv -----
// Channel  | Direction | Ports
// ---------+-----------+-------------------------------------------------------
// in       | input     | in_valid, in_ready, in_kind, in_timer_handle, in_delay_ms
// out      | output    | out_valid, out_ready, out_fired_handle
//
// Arm passes accept, remove old entry and shift-insert; cancel, accept and remove; tick,
// accept and advance time, then compare head and pop. The row of list cells does one
// shift per cycle. Unused kinds and out-of-range handles end in the accept step.
// Reset empties the list and clears time; no clearing pass is needed.
// A tick that fires waits in its compare step while a previous result is untaken.
module deadline_timer_queue #(
  parameter int SLOTS     = dtq_pkg::DEF_SLOTS,
  parameter int TIME_BITS = dtq_pkg::DEF_TIME_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [dtq_pkg::KIND_W-1:0]   in_kind,
  input  logic [dtq_pkg::HANDLE_W-1:0] in_timer_handle,
  input  logic [dtq_pkg::DELAY_W-1:0]  in_delay_ms,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [dtq_pkg::HANDLE_W-1:0] out_fired_handle
);

  // at most one entry per handle can be queued
  localparam int CELLS = (SLOTS < dtq_pkg::HANDLE_COUNT) ? SLOTS : dtq_pkg::HANDLE_COUNT;

  dtq_pkg::dtq_state_t          state_r, state_nxt;
  logic [TIME_BITS-1:0]         now_r, now_nxt;
  logic [TIME_BITS-1:0]         dl_r, dl_nxt;
  logic [dtq_pkg::HANDLE_W-1:0] key_r, key_nxt;
  logic                         arm_r, arm_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [dtq_pkg::HANDLE_W-1:0] out_handle_r, out_handle_nxt;

  dtq_pkg::dtq_ctrl_t           ctrl;
  logic                         pop;
  logic                         fire;
  logic                         handle_ok;
  logic                         accept;

  logic [CELLS-1:0]             valid_vec;
  logic [dtq_pkg::HANDLE_W-1:0] cell_handle [CELLS];
  logic [TIME_BITS-1:0]         cell_deadline [CELLS];
  logic [CELLS:0]               rm_c;
  logic [CELLS:0]               ins_c;

  assign in_ready  = (state_r == dtq_pkg::ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign handle_ok = (32'(in_timer_handle) < SLOTS);
  assign fire      = valid_vec[0] && (cell_deadline[0] <= now_r);

  assign rm_c[0]  = pop;
  assign ins_c[0] = 1'b0;

  genvar gi;
  generate
    for (gi = 0; gi < CELLS; gi++) begin : g_cell
      logic                         p_valid;
      logic [dtq_pkg::HANDLE_W-1:0] p_handle;
      logic [TIME_BITS-1:0]         p_deadline;
      logic                         n_valid;
      logic [dtq_pkg::HANDLE_W-1:0] n_handle;
      logic [TIME_BITS-1:0]         n_deadline;

      if (gi == 0) begin : g_head
        assign p_valid    = 1'b0;
        assign p_handle   = '0;
        assign p_deadline = '0;
      end else begin : g_mid
        assign p_valid    = valid_vec[gi-1];
        assign p_handle   = cell_handle[gi-1];
        assign p_deadline = cell_deadline[gi-1];
      end

      if (gi == CELLS - 1) begin : g_tail
        assign n_valid    = 1'b0;
        assign n_handle   = '0;
        assign n_deadline = '0;
      end else begin : g_body
        assign n_valid    = valid_vec[gi+1];
        assign n_handle   = cell_handle[gi+1];
        assign n_deadline = cell_deadline[gi+1];
      end

      dtq_cell #(
        .TIME_BITS(TIME_BITS)
      ) u_cell (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .new_deadline (dl_r),
        .prev_valid   (p_valid),
        .prev_handle  (p_handle),
        .prev_deadline(p_deadline),
        .prev_ins     (ins_c[gi]),
        .next_valid   (n_valid),
        .next_handle  (n_handle),
        .next_deadline(n_deadline),
        .rm_in        (rm_c[gi]),
        .rm_out       (rm_c[gi+1]),
        .ins_out      (ins_c[gi+1]),
        .valid        (valid_vec[gi]),
        .handle       (cell_handle[gi]),
        .deadline     (cell_deadline[gi])
      );
    end
  endgenerate

  always_comb begin
    state_nxt      = state_r;
    now_nxt        = now_r;
    dl_nxt         = dl_r;
    key_nxt        = key_r;
    arm_nxt        = arm_r;
    out_valid_nxt  = out_valid_r;
    out_handle_nxt = out_handle_r;
    ctrl.op        = dtq_pkg::OP_HOLD;
    ctrl.key       = key_r;
    pop            = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      dtq_pkg::ST_IDLE: begin
        if (accept) begin
          key_nxt = in_timer_handle;
          dl_nxt  = now_r + {{(TIME_BITS-dtq_pkg::DELAY_W){1'b0}}, in_delay_ms};
          case (in_kind)
            dtq_pkg::KIND_ARM: begin
              arm_nxt = 1'b1;
              if (handle_ok) begin
                state_nxt = dtq_pkg::ST_REMOVE;
              end
            end
            dtq_pkg::KIND_CANCEL: begin
              arm_nxt = 1'b0;
              if (handle_ok) begin
                state_nxt = dtq_pkg::ST_REMOVE;
              end
            end
            dtq_pkg::KIND_TICK: begin
              now_nxt   = now_r + {{(TIME_BITS-1){1'b0}}, 1'b1};
              state_nxt = dtq_pkg::ST_FIRE;
            end
            default: begin
              // drop unused kind
            end
          endcase
        end
      end
      dtq_pkg::ST_REMOVE: begin
        ctrl.op   = dtq_pkg::OP_REMOVE;
        state_nxt = arm_r ? dtq_pkg::ST_INSERT : dtq_pkg::ST_IDLE;
      end
      dtq_pkg::ST_INSERT: begin
        ctrl.op   = dtq_pkg::OP_INSERT;
        state_nxt = dtq_pkg::ST_IDLE;
      end
      dtq_pkg::ST_FIRE: begin
        if (!fire) begin
          state_nxt = dtq_pkg::ST_IDLE;
        end else if (!out_valid_r || out_ready) begin
          // pop the head into the result register
          ctrl.op        = dtq_pkg::OP_REMOVE;
          pop            = 1'b1;
          out_valid_nxt  = 1'b1;
          out_handle_nxt = cell_handle[0];
          state_nxt      = dtq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dtq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dtq_pkg::ST_IDLE;
      now_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      now_r       <= now_nxt;
      out_valid_r <= out_valid_nxt;
    end
    dl_r         <= dl_nxt;
    key_r        <= key_nxt;
    arm_r        <= arm_nxt;
    out_handle_r <= out_handle_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_fired_handle = out_handle_r;

  logic [CELLS-2:0] sorted_ok;
  generate
    for (gi = 0; gi < CELLS - 1; gi++) begin : g_sorted
      assign sorted_ok[gi] = !valid_vec[gi+1] || (cell_deadline[gi] <= cell_deadline[gi+1]);
    end
  endgenerate

  a_packed_list: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot({1'b0, valid_vec} + {{CELLS{1'b0}}, 1'b1}))
    else $error("queued entries are not contiguous from the head");

  a_sorted_list: assert property (@(posedge clk) disable iff (!rst_n)
    &sorted_ok)
    else $error("queue is not in deadline order");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == dtq_pkg::ST_INSERT |=> $countones(valid_vec) == $past($countones(valid_vec)) + 1)
    else $error("insert did not add exactly one entry");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> $countones(valid_vec) + 1 == $past($countones(valid_vec)) && out_valid)
    else $error("firing did not remove exactly one entry");

endmodule

// ----- dv/testbench.sv -----
module testbench;

  localparam int SLOTS         = dtq_pkg::DEF_SLOTS;
  localparam int TIME_BITS     = dtq_pkg::DEF_TIME_BITS;
  localparam int RANDOM_ITEMS  = 450;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 20;
  localparam logic [dtq_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [dtq_pkg::KIND_W-1:0]   kind;
    logic [dtq_pkg::HANDLE_W-1:0] handle;
    logic [dtq_pkg::DELAY_W-1:0]  delay;
  } timer_cmd_t;

  typedef struct packed {
    logic [dtq_pkg::HANDLE_W-1:0] handle;
    logic [TIME_BITS-1:0]         deadline;
  } timer_entry_t;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_SPARSE,
    RDY_EVERY_THIRD
  } ready_mode_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [dtq_pkg::KIND_W-1:0]   in_kind = '0;
  logic [dtq_pkg::HANDLE_W-1:0] in_timer_handle = '0;
  logic [dtq_pkg::DELAY_W-1:0]  in_delay_ms = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [dtq_pkg::HANDLE_W-1:0] out_fired_handle;

  // Command stream and handshake bookkeeping
  timer_cmd_t cmd_pending[$];
  int         sent_count = 0;
  int         accepted_count = 0;
  int         burst_left = 0;
  int         gap_left = 0;
  int         ready_cycle = 0;
  ready_mode_t ready_mode = RDY_ALWAYS;
  int         errors = 0;

  // Timer list mirror
  logic [TIME_BITS-1:0]           model_now = '0;
  timer_entry_t                   mirror_q[$];
  bit [dtq_pkg::HANDLE_COUNT-1:0] timer_armed = '0;
  logic [dtq_pkg::HANDLE_W-1:0]   fired_expected[$];

  deadline_timer_queue #(
    .SLOTS     (SLOTS),
    .TIME_BITS (TIME_BITS)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_timer_handle  (in_timer_handle),
    .in_delay_ms      (in_delay_ms),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_fired_handle (out_fired_handle)
  );

  always #5 clk = ~clk;

  function automatic timer_cmd_t make_cmd(input logic [dtq_pkg::KIND_W-1:0] kind,
                                          input logic [dtq_pkg::HANDLE_W-1:0] handle,
                                          input logic [dtq_pkg::DELAY_W-1:0] delay);
    timer_cmd_t cmd;
    cmd.kind   = kind;
    cmd.handle = handle;
    cmd.delay  = delay;
    return cmd;
  endfunction

  task automatic mirror_apply(input timer_cmd_t cmd);
    timer_entry_t entry;
    int pos;
    if (cmd.kind == dtq_pkg::KIND_ARM || cmd.kind == dtq_pkg::KIND_CANCEL) begin
      if (cmd.handle < SLOTS) begin
        if (timer_armed[cmd.handle]) begin
          for (int i = 0; i < mirror_q.size(); i++) begin
            if (mirror_q[i].handle == cmd.handle) begin
              mirror_q.delete(i);
              break;
            end
          end
          timer_armed[cmd.handle] = 1'b0;
        end
        if (cmd.kind == dtq_pkg::KIND_ARM) begin
          entry.handle   = cmd.handle;
          entry.deadline = model_now + TIME_BITS'(cmd.delay);
          // ties go behind existing entries
          pos = 0;
          while (pos < mirror_q.size() && mirror_q[pos].deadline <= entry.deadline)
            pos++;
          mirror_q.insert(pos, entry);
          timer_armed[cmd.handle] = 1'b1;
        end
      end
    end else if (cmd.kind == dtq_pkg::KIND_TICK) begin
      model_now = model_now + 1'b1;
      if (mirror_q.size() > 0 && mirror_q[0].deadline <= model_now) begin
        entry = mirror_q.pop_front();
        timer_armed[entry.handle] = 1'b0;
        fired_expected.push_back(entry.handle);
      end
    end
  endtask

  // Driver: present the next command once the previous transaction is taken
  always @(negedge clk) begin
    timer_cmd_t staged;
    if (rst_n) begin
      if (in_valid && accepted_count != sent_count) begin
        // hold the transaction until accepted
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (cmd_pending.size() > 0) begin
        staged = cmd_pending.pop_front();
        in_valid        <= 1'b1;
        in_kind         <= staged.kind;
        in_timer_handle <= staged.handle;
        in_delay_ms     <= staged.delay;
        sent_count++;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: drives out_ready from a stall pattern that is switched at random
  always @(negedge clk) begin
    ready_cycle++;
    if (ready_cycle % 50 == 0)
      ready_mode = ready_mode_t'($urandom_range(0, 3));
    case (ready_mode)
      RDY_ALWAYS: begin
        out_ready <= 1'b1;
      end
      RDY_COIN: begin
        out_ready <= 1'($urandom_range(0, 1));
      end
      RDY_SPARSE: begin
        out_ready <= ($urandom_range(0, 5) == 0);
      end
      default: begin
        out_ready <= (ready_cycle % 3 == 0);
      end
    endcase
  end

  // Monitor: check results before predicting from a transaction in the same cycle
  always @(posedge clk) begin
    logic [dtq_pkg::HANDLE_W-1:0] want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (fired_expected.size() == 0) begin
          $error("unexpected transaction on out: fired_handle %0d", out_fired_handle);
          errors++;
        end else begin
          want = fired_expected.pop_front();
          if (out_fired_handle !== want) begin
            $error("fired_handle mismatch: expected %0d, actual %0d", want, out_fired_handle);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        mirror_apply(make_cmd(in_kind, in_timer_handle, in_delay_ms));
        accepted_count++;
      end
    end
  end

  initial begin
    int total_items;
    int counted;
    int roll;
    int drain;
    timer_cmd_t cmd;

    cmd_pending.push_back(make_cmd(dtq_pkg::KIND_TICK, 4'd0, 32'd0));
    cmd_pending.push_back(make_cmd(dtq_pkg::KIND_CANCEL, 4'd5, 32'd0));
    cmd_pending.push_back(make_cmd(KIND_UNUSED, 4'd15, 32'hFFFF_FFFF));
    cmd_pending.push_back(make_cmd(dtq_pkg::KIND_ARM, 4'd0, 32'd0));
    cmd_pending.push_back(make_cmd(dtq_pkg::KIND_TICK, 4'd0, 32'd0));
    cmd_pending.push_back(make_cmd(dtq_pkg::KIND_ARM, 4'd15, 32'hFFFF_FFFF));
    cmd_pending.push_back(make_cmd(dtq_pkg::KIND_ARM, 4'd1, 32'd2));
    cmd_pending.push_back(make_cmd(dtq_pkg::KIND_ARM, 4'd2, 32'd2));
    cmd_pending.push_back(make_cmd(dtq_pkg::KIND_ARM, 4'd3, 32'd1));
    // re-arm moves the handle behind its tie
    cmd_pending.push_back(make_cmd(dtq_pkg::KIND_ARM, 4'd1, 32'd2));
    cmd_pending.push_back(make_cmd(dtq_pkg::KIND_CANCEL, 4'd2, 32'd0));
    // several already expired: one per tick
    cmd_pending.push_back(make_cmd(dtq_pkg::KIND_ARM, 4'd4, 32'd0));
    cmd_pending.push_back(make_cmd(dtq_pkg::KIND_ARM, 4'd5, 32'd0));
    cmd_pending.push_back(make_cmd(dtq_pkg::KIND_ARM, 4'd6, 32'd0));
    repeat (6) cmd_pending.push_back(make_cmd(dtq_pkg::KIND_TICK, 4'd0, 32'd0));
    cmd_pending.push_back(make_cmd(dtq_pkg::KIND_CANCEL, 4'd15, 32'd0));
    cmd_pending.push_back(make_cmd(dtq_pkg::KIND_ARM, 4'd0, 32'd0));
    cmd_pending.push_back(make_cmd(dtq_pkg::KIND_CANCEL, 4'd0, 32'd0));
    cmd_pending.push_back(make_cmd(dtq_pkg::KIND_TICK, 4'd0, 32'd0));

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      cmd.handle = dtq_pkg::HANDLE_W'($urandom_range(0, 15));
      cmd.delay  = $urandom;
      if (roll < 35) begin
        cmd.kind = dtq_pkg::KIND_ARM;
        roll = $urandom_range(0, 99);
        if (roll < 85)
          cmd.delay = $urandom_range(0, 24);
        else if (roll < 95)
          cmd.delay = $urandom_range(25, 300);
      end else if (roll < 50) begin
        cmd.kind = dtq_pkg::KIND_CANCEL;
      end else if (roll < 95) begin
        cmd.kind = dtq_pkg::KIND_TICK;
      end else begin
        cmd.kind = KIND_UNUSED;
      end
      cmd_pending.push_back(cmd);
      if (cmd.kind != KIND_UNUSED)
        counted++;
    end
    total_items = cmd_pending.size();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (accepted_count < total_items)
      @(negedge clk);
    drain = 0;
    while (fired_expected.size() != 0 && drain < DRAIN_LIMIT) begin
      @(negedge clk);
      drain++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fired_expected.size() != 0) begin
      $error("%0d expected fired_handle results never arrived", fired_expected.size());
      errors++;
    end

    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
